FILE: rtl/mev_pkg.sv
// mev_pkg: shared widths, codes and record types of the motion event detector.
// No dependencies; every other file uses this package.
package mev_pkg;

    // Core sizing
    localparam int COMPONENTS  = 4;
    localparam int VALUE_BITS  = 32;
    localparam int NUM_FIELDS  = 4;
    localparam int DT_BITS     = 20;
    localparam int PERIOD_BITS = 20;
    localparam int THR_BITS    = 31;
    localparam int ACCUM_BITS  = 22;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 31;
    localparam int CMP_BITS = (VALUE_BITS + 1 > THR_BITS) ? VALUE_BITS + 1 : THR_BITS;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    localparam t_value VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_value VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Register map
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd2;

    localparam logic                   RST_ENABLE    = 1'b0;
    localparam logic [PERIOD_BITS-1:0] RST_PERIOD    = 20'd16667;
    localparam logic [THR_BITS-1:0]    RST_THRESHOLD = 31'd7;

    typedef enum logic [1:0] {
        KIND_BASELINE = 2'd0,
        KIND_START    = 2'd1,
        KIND_SAMPLE   = 2'd2,
        KIND_END      = 2'd3
    } t_kind;

    // Per-lane state update strobes
    typedef struct packed {
        logic load_last;
        logic load_start;
    } t_lane_ctl;

    // One tick's results: optional Start followed by one valued event
    typedef struct packed {
        logic                    has_start;
        t_kind                   kind;
        t_value [NUM_FIELDS-1:0] vals;
    } t_rec;

endpackage

FILE: rtl/mev_intf.sv
// mev_intf: valid/ready channel interfaces of the motion event detector.
// Depends on mev_pkg for widths and types.
interface mev_item_if;
    logic                          valid;
    logic                          ready;
    logic [mev_pkg::DT_BITS-1:0]   dt_us;
    logic                          sample_valid;
    mev_pkg::t_value               value_0;
    mev_pkg::t_value               value_1;
    mev_pkg::t_value               value_2;
    mev_pkg::t_value               value_3;

    modport source (output valid, dt_us, sample_valid, value_0, value_1, value_2, value_3,
                    input ready);
    modport sink   (input valid, dt_us, sample_valid, value_0, value_1, value_2, value_3,
                    output ready);
endinterface

interface mev_event_if;
    logic            valid;
    logic            ready;
    mev_pkg::t_kind  event_kind;
    mev_pkg::t_value out_0;
    mev_pkg::t_value out_1;
    mev_pkg::t_value out_2;
    mev_pkg::t_value out_3;
    logic            last;

    modport source (output valid, event_kind, out_0, out_1, out_2, out_3, last,
                    input ready);
    modport sink   (input valid, event_kind, out_0, out_1, out_2, out_3, last,
                    output ready);
endinterface

interface mev_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mev_pkg::CFG_IDX_BITS-1:0]  index;
    logic [mev_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mev_lane.sv
// mev_lane: one component lane; holds last sent and motion start values,
// flags change against the threshold and forms the saturated End delta. Uses mev_pkg.
module mev_lane (
    input  logic                       i_clk,
    input  mev_pkg::t_value            i_cur,
    input  logic [mev_pkg::THR_BITS-1:0] i_threshold,
    input  mev_pkg::t_lane_ctl         i_ctl,
    output logic                       o_changed,
    output mev_pkg::t_value            o_delta
);
    import mev_pkg::*;

    t_value                   r_last_sent;
    t_value                   r_start;
    logic [VALUE_BITS:0]      diff;
    logic [VALUE_BITS:0]      mag;
    logic [VALUE_BITS:0]      delta_wide;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_start) begin
            r_start <= r_last_sent;
        end
        if (i_ctl.load_last) begin
            r_last_sent <= i_cur;
        end
    end

    // sign-extended difference, magnitude fits VALUE_BITS+1 unsigned
    always_comb begin
        diff = {i_cur[VALUE_BITS-1], i_cur} - {r_last_sent[VALUE_BITS-1], r_last_sent};
        mag  = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;
        o_changed = CMP_BITS'(mag) > CMP_BITS'(i_threshold);
    end

    always_comb begin
        delta_wide = {i_cur[VALUE_BITS-1], i_cur} - {r_start[VALUE_BITS-1], r_start};
        if (delta_wide[VALUE_BITS] != delta_wide[VALUE_BITS-1]) begin
            o_delta = delta_wide[VALUE_BITS] ? VAL_MIN : VAL_MAX;
        end else begin
            o_delta = delta_wide[VALUE_BITS-1:0];
        end
    end

endmodule

FILE: rtl/mev_out_queue.sv
// mev_out_queue: two-deep queue of per-tick result records, expanded into
// one or two output transactions (Start, then the valued event). Uses mev_pkg, mev_intf.
module mev_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  mev_pkg::t_rec    i_rec,
    output logic             o_ready,
    mev_event_if.source      o_event
);
    import mev_pkg::*;

    t_rec       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_sub;
    logic [1:0] n_count;

    t_rec head;
    logic show_start;
    logic pop;
    logic done;

    always_comb begin
        head       = r_mem[r_rd_ptr];
        show_start = head.has_start && !r_sub;
        o_event.valid      = (r_count != 2'd0);
        o_event.event_kind = show_start ? KIND_START : head.kind;
        o_event.out_0      = show_start ? '0 : head.vals[0];
        o_event.out_1      = show_start ? '0 : head.vals[1];
        o_event.out_2      = show_start ? '0 : head.vals[2];
        o_event.out_3      = show_start ? '0 : head.vals[3];
        o_event.last       = !show_start;
        pop  = o_event.valid && o_event.ready;
        done = pop && !show_start;
        o_ready = (r_count != 2'd2) || done;
        n_count = r_count + {1'b0, i_wr} - {1'b0, done};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (done) begin
                r_rd_ptr <= !r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (pop) begin
                r_sub <= 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count above depth");

    a_sub_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> r_count != 2'd0)
        else $error("second half pending on empty queue");

    a_start_then_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.ready && !o_event.last) |=>
        (o_event.valid && o_event.event_kind == KIND_SAMPLE))
        else $error("Start not followed by Sample");

endmodule

FILE: rtl/motion_event_detector_unit.sv
// motion_event_detector_unit: top level; register file, time decimation,
// per-component lanes with merge, and the result queue. Uses mev_pkg, mev_intf, mev_lane, mev_out_queue.
//
// A tick transaction can be accepted every clock cycle unless a full result
// queue holds the lane stage. At acceptance, while tracing is enabled, the time
// accumulator is advanced by dt_us and decides whether the tick is a sample; a
// sampled tick with valid values moves into one register stage where four
// component lanes compare it against the last sent values in parallel and a
// merge step picks Baseline, Start+Sample, Sample, End or no result. The block
// sustains one tick per cycle while each tick gives at most one result and the
// event channel is ready; a tick that gives Start and Sample occupies the event
// channel for two transactions, and the two-record result queue then holds the
// input back. Unsampled ticks and ticks while tracing is off give no transaction.
// Configuration writes are always accepted (ready tied high); writes to an
// unknown index are dropped. The last-sent and motion-start values have no
// reset; they are loaded before any path reads them.
module motion_event_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mev_cfg_if.sink     i_cfg,
    mev_item_if.sink    i_item,
    mev_event_if.source o_event
);
    import mev_pkg::*;

    // configuration registers
    logic                   r_enable;
    logic [PERIOD_BITS-1:0] r_period;
    logic [THR_BITS-1:0]    r_threshold;

    // tracer state
    logic [ACCUM_BITS-1:0]  r_accum;
    logic                   r_have_baseline;
    logic                   r_moving;

    // lane stage
    logic                    r_b_valid;
    t_value [NUM_FIELDS-1:0] r_b_vals;

    logic                   in_fire;
    logic                   b_fire;
    logic                   q_ready;
    logic                   q_wr;
    t_rec                   q_rec;

    logic [PERIOD_BITS-1:0] period_eff;
    logic [ACCUM_BITS-1:0]  sum;
    logic [ACCUM_BITS-1:0]  rem;
    logic                   hit;
    logic                   too_far;

    t_value [NUM_FIELDS-1:0] in_vals;
    t_value [NUM_FIELDS-1:0] lane_delta;
    logic   [NUM_FIELDS-1:0] lane_changed;
    logic                    any_changed;
    t_lane_ctl               lane_ctl;

    // Configuration port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= RST_ENABLE;
            r_period    <= RST_PERIOD;
            r_threshold <= RST_THRESHOLD;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ENABLE:    r_enable    <= i_cfg.data[0];
                CFG_PERIOD:    r_period    <= i_cfg.data[PERIOD_BITS-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg.data[THR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Decimation: a zero period behaves as one microsecond; after a sample
    // the remainder is dropped if it exceeds two periods (no catch-up).
    always_comb begin
        period_eff = (r_period == '0) ? PERIOD_BITS'(1) : r_period;
        sum        = r_accum + ACCUM_BITS'(i_item.dt_us);
        hit        = sum >= ACCUM_BITS'(period_eff);
        rem        = sum - ACCUM_BITS'(period_eff);
        too_far    = rem > ACCUM_BITS'({period_eff, 1'b0});
    end

    assign in_vals[0] = i_item.value_0;
    assign in_vals[1] = i_item.value_1;
    assign in_vals[2] = i_item.value_2;
    assign in_vals[3] = i_item.value_3;

    assign i_item.ready = !r_b_valid || q_ready;
    assign in_fire      = i_item.valid && i_item.ready;
    assign b_fire       = r_b_valid && q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum   <= '0;
            r_b_valid <= 1'b0;
        end else if (in_fire) begin
            r_b_valid <= r_enable && hit && i_item.sample_valid;
            if (r_enable) begin
                r_accum <= hit ? (too_far ? '0 : rem) : sum;
            end
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    // unused components carry zero so they drop out of every result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_b_vals[k] <= (k < COMPONENTS) ? in_vals[k] : '0;
            end
        end
    end

    // Component lanes
    for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_lane
        if (g < COMPONENTS) begin : g_used
            mev_lane u_lane (
                .i_clk       (i_clk),
                .i_cur       (r_b_vals[g]),
                .i_threshold (r_threshold),
                .i_ctl       (lane_ctl),
                .o_changed   (lane_changed[g]),
                .o_delta     (lane_delta[g])
            );
        end else begin : g_unused
            assign lane_changed[g] = 1'b0;
            assign lane_delta[g]   = '0;
        end
    end

    // Merge: one decision per sampled tick from the lanes' change flags
    always_comb begin
        any_changed         = |lane_changed;
        lane_ctl.load_last  = b_fire && (!r_have_baseline || any_changed);
        lane_ctl.load_start = b_fire && r_have_baseline && any_changed && !r_moving;

        q_wr          = b_fire && (!r_have_baseline || any_changed || r_moving);
        q_rec.has_start = r_have_baseline && any_changed && !r_moving;
        if (!r_have_baseline) begin
            q_rec.kind = KIND_BASELINE;
            q_rec.vals = r_b_vals;
        end else if (any_changed) begin
            q_rec.kind = KIND_SAMPLE;
            q_rec.vals = r_b_vals;
        end else begin
            q_rec.kind = KIND_END;
            q_rec.vals = lane_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_baseline <= 1'b0;
            r_moving        <= 1'b0;
        end else if (b_fire) begin
            if (!r_have_baseline) begin
                r_have_baseline <= 1'b1;
            end else if (any_changed) begin
                r_moving <= 1'b1;
            end else begin
                r_moving <= 1'b0;
            end
        end
    end

    mev_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_rec   (q_rec),
        .o_ready (q_ready),
        .o_event (o_event)
    );

    a_moving_has_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> r_have_baseline)
        else $error("motion without baseline");

    a_wr_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> q_ready)
        else $error("result record written into full queue");

    a_disabled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_enable) |=> (r_accum == $past(r_accum) && !r_b_valid))
        else $error("disabled tick changed state");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench of motion_event_detector_unit. Drives ticks and register
// writes, predicts the trace events in a scoreboard class and checks every event transaction.
// Depends on mev_pkg, the mev channel interfaces and the RTL top level.
module tb_top;
    import mev_pkg::*;

    // Index that the register map leaves unused; writes to it must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam int SEG_TICKS     = 136;   // random ticks per configuration segment
    localparam int SETTLE_CYCLES = 8;     // quiet margin after the last due event for the lane stage
    localparam int STALL_LIMIT   = 4000;  // cycles without any transaction before giving up
    localparam int HOLD_CYCLES   = 300;   // long event back-pressure stretch
    localparam int DT_MAX        = 1000000;

    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = 20'd1000000;
    localparam logic [THR_BITS-1:0]    THR_MAX    = 31'h7FFF_FFFF;

    // One tick as it crosses the item channel
    typedef struct packed {
        logic [DT_BITS-1:0]      dt;
        logic                    sv;
        t_value [NUM_FIELDS-1:0] vals;
    } t_tick;

    // One event as it crosses the event channel
    typedef struct {
        t_kind  kind;
        t_value vals[NUM_FIELDS];
        logic   last;
    } t_trace_event;

    // Scoreboard: keeps its own copy of the registers and the tracer state, turns every
    // accepted tick into the events it must cause and checks events in arrival order.
    class trace_scoreboard;
        bit                     enable;
        logic [PERIOD_BITS-1:0] period;
        logic [THR_BITS-1:0]    thresh;
        logic [ACCUM_BITS-1:0]  accum;
        bit                     have_base;
        bit                     moving;
        t_value                 last_sent[NUM_FIELDS];
        t_value                 start_vals[NUM_FIELDS];
        t_trace_event           events_due[$];
        int                     errors;

        function new();
            enable    = RST_ENABLE;
            period    = RST_PERIOD;
            thresh    = RST_THRESHOLD;
            accum     = '0;
            have_base = 1'b0;
            moving    = 1'b0;
            errors    = 0;
            foreach (last_sent[i]) begin
                last_sent[i]  = '0;
                start_vals[i] = '0;
            end
        endfunction

        // append one predicted event behind the ones already due
        function void add_due(t_trace_event ev);
            events_due = {events_due, ev};
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_ENABLE:    enable = data[0];
                CFG_PERIOD:    period = data[PERIOD_BITS-1:0];
                CFG_THRESHOLD: thresh = data[THR_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void log_tick(t_tick t);
            int unsigned  per;
            longint       diff;
            bit           changed;
            t_trace_event ev;
            if (!enable)
                return;
            // decimation; a zero period behaves as one microsecond
            per   = (period == 0) ? 1 : period;
            accum = accum + t.dt;
            if (accum < per)
                return;
            accum = accum - per;
            if (accum > 2 * per)
                accum = '0;   // far behind: drop the backlog instead of bursting
            if (!t.sv)
                return;
            ev.last = 1'b1;
            if (!have_base) begin
                ev.kind = KIND_BASELINE;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    ev.vals[i]   = t.vals[i];
                    last_sent[i] = t.vals[i];
                end
                have_base = 1'b1;
                add_due(ev);
                return;
            end
            changed = 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                diff = longint'($signed(t.vals[i])) - longint'(last_sent[i]);
                if (diff < 0)
                    diff = -diff;
                if (diff > longint'(thresh))
                    changed = 1'b1;
            end
            if (changed) begin
                if (!moving) begin
                    ev.kind = KIND_START;
                    ev.last = 1'b0;
                    for (int i = 0; i < NUM_FIELDS; i++) begin
                        ev.vals[i]    = '0;
                        start_vals[i] = last_sent[i];
                    end
                    add_due(ev);
                    moving = 1'b1;
                end
                ev.kind = KIND_SAMPLE;
                ev.last = 1'b1;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    ev.vals[i]   = t.vals[i];
                    last_sent[i] = t.vals[i];
                end
                add_due(ev);
            end else if (moving) begin
                // End carries the change since motion began, saturated to the value width
                ev.kind = KIND_END;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    diff = longint'($signed(t.vals[i])) - longint'(start_vals[i]);
                    if (diff > longint'(VAL_MAX))
                        ev.vals[i] = VAL_MAX;
                    else if (diff < longint'(VAL_MIN))
                        ev.vals[i] = VAL_MIN;
                    else
                        ev.vals[i] = t_value'(diff);
                end
                add_due(ev);
                moving = 1'b0;
            end
        endfunction

        function void check_event(t_trace_event got);
            t_trace_event want;
            if (events_due.size() == 0) begin
                $error("unexpected event transaction: event_kind %0d", got.kind);
                errors++;
                return;
            end
            want = events_due.pop_front();
            if (got.kind !== want.kind) begin
                $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            for (int i = 0; i < NUM_FIELDS; i++) begin
                if (got.vals[i] !== want.vals[i]) begin
                    $error("out_%0d: expected %0d, actual %0d", i, want.vals[i], got.vals[i]);
                    errors++;
                end
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mev_item_if  item_if();
    mev_event_if event_if();
    mev_cfg_if   cfg_if();

    motion_event_detector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_item  (item_if),
        .o_event (event_if)
    );

    trace_scoreboard sb = new();

    int     src_idle_pct;      // chance per tick that the sender inserts an idle cycle
    int     sink_idle_pct;     // chance per cycle that the event sink stalls
    int     hold_req;          // nonzero asks the sink for one long stall of that many cycles
    int     stall_cycles = 0;  // cycles since the last transaction on any channel
    t_value held[NUM_FIELDS];  // current component values seen by the random sender

    always #4 i_clk = ~i_clk;

    // Monitor. Everything is sampled at the rising edge, before the edge's own updates land,
    // so each channel is seen exactly as the DUT saw it. Events are checked before the tick of
    // the same edge is logged; an event can never belong to a tick accepted at that edge.
    always @(posedge i_clk) begin
        t_trace_event got;
        t_tick        tk;
        if (event_if.valid === 1'b1 && event_if.ready === 1'b1) begin
            got.kind    = event_if.event_kind;
            got.vals[0] = event_if.out_0;
            got.vals[1] = event_if.out_1;
            got.vals[2] = event_if.out_2;
            got.vals[3] = event_if.out_3;
            got.last    = event_if.last;
            sb.check_event(got);
        end
        if (item_if.valid === 1'b1 && item_if.ready === 1'b1) begin
            tk.dt      = item_if.dt_us;
            tk.sv      = item_if.sample_valid;
            tk.vals[0] = item_if.value_0;
            tk.vals[1] = item_if.value_1;
            tk.vals[2] = item_if.value_2;
            tk.vals[3] = item_if.value_3;
            sb.log_tick(tk);
        end
        if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
            sb.write_reg(cfg_if.index, cfg_if.data);
    end

    // Progress watchdog: any transaction on any channel resets the count
    always @(posedge i_clk) begin
        if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
            (event_if.valid === 1'b1 && event_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Event sink: random stalls, plus one long hold-off on request. The hold is counted
    // here so the sender keeps offering ticks and the result queue fills up behind it.
    initial begin
        int n;
        event_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n        = hold_req;
                hold_req = 0;
                event_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                event_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offer one tick, with random idle cycles in front, and return at the edge that
    // accepts it. valid stays high into a following tick; only an idle cycle or settle() drops it.
    task automatic send_tick(t_tick t);
        while ($urandom_range(99) < src_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.dt_us        <= t.dt;
        item_if.sample_valid <= t.sv;
        item_if.value_0      <= t.vals[0];
        item_if.value_1      <= t.vals[1];
        item_if.value_2      <= t.vals[2];
        item_if.value_3      <= t.vals[3];
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
    endtask

    task automatic send_vals(int unsigned dt, bit sv, t_value v0, t_value v1, t_value v2,
                             t_value v3);
        t_tick t;
        t.dt      = DT_BITS'(dt);
        t.sv      = sv;
        t.vals[0] = v0;
        t.vals[1] = v1;
        t.vals[2] = v2;
        t.vals[3] = v3;
        send_tick(t);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let the pipeline drain: every predicted event delivered, then a few quiet cycles so
    // that ticks without any event have also cleared the compare stage.
    task automatic settle();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.events_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reconfigure(bit en, logic [PERIOD_BITS-1:0] per, logic [THR_BITS-1:0] thr);
        settle();
        cfg_write(CFG_ENABLE, CFG_DATA_BITS'(en));
        cfg_write(CFG_PERIOD, CFG_DATA_BITS'(per));
        cfg_write(CFG_THRESHOLD, thr);
    endtask

    // Step a component to just at or just past the change threshold, either direction
    function automatic t_value nudge(t_value base);
        logic [VALUE_BITS-1:0] step;
        step = {1'b0, sb.thresh} + VALUE_BITS'($urandom_range(1));
        return ($urandom_range(1) != 0) ? base + step : base - step;
    endfunction

    // Random tick. dt is mostly near the current period so that ticks get sampled; values
    // mostly hold or move a little so that motion starts, continues and ends, with the
    // rest being wide jumps and extremes.
    function automatic t_tick next_tick();
        t_tick       t;
        int unsigned per;
        int unsigned span;
        int unsigned pick;
        int unsigned k;
        per  = (sb.period == 0) ? 1 : sb.period;
        span = (2 * per > DT_MAX) ? DT_MAX : 2 * per;
        pick = $urandom_range(99);
        if (pick < 8)
            t.dt = '0;
        else if (pick < 14)
            t.dt = DT_BITS'($urandom_range(DT_MAX));
        else if (pick < 17)
            t.dt = DT_BITS'(DT_MAX);
        else if (pick < 30)
            t.dt = DT_BITS'(per);
        else
            t.dt = DT_BITS'($urandom_range(span));
        t.sv = ($urandom_range(99) < 90);

        pick = $urandom_range(99);
        if (pick < 35) begin
            // all components hold: ends motion or stays quiet
        end else if (pick < 60) begin
            k       = $urandom_range(NUM_FIELDS - 1);
            held[k] = nudge(held[k]);
        end else if (pick < 85) begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
                case ($urandom_range(3))
                    0: ;
                    1: held[i] = nudge(held[i]);
                    2: held[i] = held[i] + $urandom_range(32) - 16;
                    default: held[i] = $urandom;
                endcase
            end
        end else begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
                if ($urandom_range(3) != 0)
                    held[i] = $urandom;
                else begin
                    case ($urandom_range(3))
                        0: held[i] = VAL_MIN;
                        1: held[i] = VAL_MAX;
                        2: held[i] = '0;
                        default: held[i] = '1;
                    endcase
                end
            end
        end
        for (int i = 0; i < NUM_FIELDS; i++)
            t.vals[i] = held[i];
        return t;
    endfunction

    task automatic run_segment(int n);
        for (int k = 0; k < n; k++)
            send_tick(next_tick());
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.dt_us        <= '0;
        item_if.sample_valid <= 1'b0;
        item_if.value_0      <= '0;
        item_if.value_1      <= '0;
        item_if.value_2      <= '0;
        item_if.value_3      <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= '0;
        cfg_if.data          <= '0;
        src_idle_pct  = 11;
        sink_idle_pct = 72;
        hold_req      = 0;
        foreach (held[i])
            held[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // Tracing is off after reset: these ticks must neither emit nor move the accumulator
        send_vals(DT_MAX, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
        send_vals(20000, 1'b1, VAL_MIN, '0, '1, VAL_MAX);

        // Period one, zero threshold: any difference at all is motion
        reconfigure(1'b1, 20'd1, '0);
        cfg_write(CFG_UNUSED, '1);   // must not touch any register

        send_vals(0, 1'b1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);    // accumulator short: skipped
        send_vals(1, 1'b0, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);    // sampled, values invalid
        send_vals(1, 1'b1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);    // baseline
        send_vals(1, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);    // start + sample
        send_vals(1, 1'b1, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);    // end, delta clips high
        send_vals(1, 1'b1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);    // start + sample
        send_vals(1, 1'b1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);    // end, delta clips low
        send_vals(1, 1'b1, '0, '1, 32'sd1, 32'sh1234_5678);        // start + sample
        send_vals(1, 1'b1, '0, '1, 32'sd1, 32'sh1234_5679);        // sample while moving
        send_vals(1, 1'b1, '0, '1, 32'sd1, 32'sh1234_5679);        // end
        send_vals(1, 1'b1, '0, '1, 32'sd1, 32'sh1234_5679);        // quiet, nothing
        // Huge dt: one sample, then the backlog beyond two periods is dropped
        send_vals(DT_MAX, 1'b1, 32'sd5, 32'sd5, 32'sd5, 32'sd5);
        send_vals(0, 1'b1, 32'sd9, 32'sd9, 32'sd9, 32'sd9);        // accumulator empty: skipped
        send_vals(1, 1'b1, 32'sd5, 32'sd5, 32'sd5, 32'sd5);        // end

        // Zero period acts as one; threshold back at its reset value
        reconfigure(1'b1, '0, RST_THRESHOLD);
        send_vals(1, 1'b1, 32'sd12, 32'sd5, 32'sd5, 32'sd5);       // exactly at threshold: quiet
        send_vals(1, 1'b1, 32'sd5, 32'sd5, 32'sd5, -32'sd3);       // just above: start + sample
        send_vals(1, 1'b1, 32'sd5, 32'sd5, 32'sd5, -32'sd3);       // end
        send_vals(0, 1'b1, '1, '1, '1, '1);                        // skipped

        // ---- random part ----
        // Sender mostly busy, event sink mostly stalled
        reconfigure(1'b1, 20'd1, '0);
        run_segment(SEG_TICKS);
        reconfigure(1'b1, 20'd3, RST_THRESHOLD);
        run_segment(SEG_TICKS);

        // Sender mostly idle, sink mostly ready
        src_idle_pct  = 72;
        sink_idle_pct = 11;
        reconfigure(1'b1, PERIOD_MAX, THR_BITS'($urandom_range(65536)));
        run_segment(SEG_TICKS);
        reconfigure(1'b1, 20'd50, THR_MAX);
        run_segment(SEG_TICKS);

        // Tracing paused: state must survive untouched
        reconfigure(1'b0, 20'd50, THR_MAX);
        run_segment(15);

        // No idling; a long sink hold-off first so the result queue backs up into the input
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        reconfigure(1'b1, 20'd2, 31'd1000);
        hold_req = HOLD_CYCLES;
        run_segment(SEG_TICKS);
        reconfigure(1'b1, '0, 31'h0001_0000);
        run_segment(SEG_TICKS);

        settle();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
